// ===== hdl/fifo_writeback_block_cache_directory_core_assert.svh =====
// Assertion macros for the block cache directory core.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef FIFO_WRITEBACK_BLOCK_CACHE_DIRECTORY_CORE_ASSERT_SVH
`define FIFO_WRITEBACK_BLOCK_CACHE_DIRECTORY_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FWBC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FWBC_ASSERT(lbl, ante, cons, msg)
`define FWBC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/fwbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and index helpers of the block cache directory.
// No dependencies; used by fwbc_dir_store and the top level.
package fwbc_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int TAG_BITS    = 24;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam int BLK_W  = 24;
  localparam int SLOT_W = 4;
  localparam int REQ_W  = 2;
  localparam int WAYS_W = 5;

  localparam logic [WAYS_W-1:0] WAYS_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SYNC  = 2'd2;

  typedef struct packed {
    logic                tag_we;
    logic                dirty_we;
    logic [IDX_W-1:0]    idx;
    logic [TAG_BITS-1:0] tag;
    logic                dirty;
  } wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] occ;
    logic [CNT_W-1:0] pos;
  } query_t;

  // Entry index of FIFO position off counted from base, modulo the entry count.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(NUM_ENTRIES)) begin
      s = s - SUM_W'(NUM_ENTRIES);
    end
    return IDX_W'(s);
  endfunction

  // FIFO position of entry e given the oldest entry head.
  function automatic logic [CNT_W-1:0] fifo_pos(input logic [IDX_W-1:0] e,
                                                input logic [IDX_W-1:0] head);
    logic [SUM_W-1:0] s;
    if (e >= head) begin
      s = SUM_W'(e) - SUM_W'(head);
    end else begin
      s = SUM_W'(e) + SUM_W'(NUM_ENTRIES) - SUM_W'(head);
    end
    return CNT_W'(s);
  endfunction

endpackage

// ===== hdl/fwbc_dir_store.sv =====
`timescale 1ns / 1ps
// Tag and dirty store of the directory with the shared tag comparator.
// Depends on fwbc_pkg.
module fwbc_dir_store (
  input  logic                           clk_i,
  input  fwbc_pkg::query_t               query_i,
  input  logic [fwbc_pkg::TAG_BITS-1:0]  key_i,
  input  fwbc_pkg::wr_t                  wr_i,
  output logic [fwbc_pkg::TAG_BITS-1:0]  rd_tag_o,
  output logic                           rd_dirty_o,
  output logic                           tag_eq_o,
  output logic                           later_dirty_o
);

  logic [fwbc_pkg::TAG_BITS-1:0]    tag_q   [fwbc_pkg::NUM_ENTRIES];
  logic [fwbc_pkg::NUM_ENTRIES-1:0] dirty_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.tag_we) begin
      tag_q[wr_i.idx] <= wr_i.tag;
    end
    if (wr_i.dirty_we) begin
      dirty_q[wr_i.idx] <= wr_i.dirty;
    end
  end

  assign rd_tag_o   = tag_q[query_i.idx];
  assign rd_dirty_o = dirty_q[query_i.idx];
  assign tag_eq_o   = (tag_q[query_i.idx] == key_i);

  // Any live dirty entry younger than the current walk position.
  always_comb begin
    logic [fwbc_pkg::CNT_W-1:0] p;
    later_dirty_o = 1'b0;
    for (int e = 0; e < fwbc_pkg::NUM_ENTRIES; e++) begin
      p = fwbc_pkg::fifo_pos(fwbc_pkg::IDX_W'(e), query_i.head);
      if (dirty_q[e] && (p < query_i.occ) && (p > query_i.pos)) begin
        later_dirty_o = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fifo_writeback_block_cache_directory_core.sv =====
`timescale 1ns / 1ps
// Top level of the FIFO-replacement write-back block cache directory.
// Depends on fwbc_pkg, fwbc_dir_store and the assertion macro header.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | in        | in_valid_i / in_stall_o   | req_type_i, block_number_i
//   out     | out       | out_valid_o / out_stall_i | hit_o, slot_o, fill_valid_o,
//           |           |                           | fill_block_o, wb_valid_o, wb_block_o,
//           |           |                           | last_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_active_ways_i
//
// One transaction is taken in idle; the walk then compares one entry per cycle in FIFO order.
// The walk holds at a hit, a dirty entry or its end while the output register is full and stalled.
// Reset clears head, occupancy and the output register; tags and dirty marks start undefined.
`include "fifo_writeback_block_cache_directory_core_assert.svh"
module fifo_writeback_block_cache_directory_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fwbc_pkg::REQ_W-1:0]    req_type_i,
  input  logic [fwbc_pkg::BLK_W-1:0]    block_number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [fwbc_pkg::SLOT_W-1:0]   slot_o,
  output logic                          fill_valid_o,
  output logic [fwbc_pkg::BLK_W-1:0]    fill_block_o,
  output logic                          wb_valid_o,
  output logic [fwbc_pkg::BLK_W-1:0]    wb_block_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fwbc_pkg::WAYS_W-1:0]   cfg_active_ways_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SYNC} state_e;

  state_e                         state_q, state_d;
  logic [fwbc_pkg::IDX_W-1:0]     head_q, head_d;
  logic [fwbc_pkg::CNT_W-1:0]     occ_q, occ_d;
  logic [fwbc_pkg::CNT_W-1:0]     pos_q, pos_d;
  logic [fwbc_pkg::WAYS_W-1:0]    ways_q;
  logic [fwbc_pkg::BLK_W-1:0]     blk_q, blk_d;
  logic                           wr_req_q, wr_req_d;

  logic                           out_valid_q, out_valid_d;
  logic                           hit_q, hit_d;
  logic [fwbc_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic                           fill_valid_q, fill_valid_d;
  logic [fwbc_pkg::BLK_W-1:0]     fill_block_q, fill_block_d;
  logic                           wb_valid_q, wb_valid_d;
  logic [fwbc_pkg::BLK_W-1:0]     wb_block_q, wb_block_d;
  logic                           last_q, last_d;

  fwbc_pkg::query_t               query;
  fwbc_pkg::wr_t                  wr;
  logic [fwbc_pkg::TAG_BITS-1:0]  key;
  logic [fwbc_pkg::TAG_BITS-1:0]  rd_tag;
  logic                           rd_dirty;
  logic                           tag_eq;
  logic                           later_dirty;

  logic [fwbc_pkg::IDX_W-1:0]     walk_idx;
  logic [fwbc_pkg::IDX_W-1:0]     append_idx;
  logic [fwbc_pkg::CNT_W-1:0]     limit;
  logic                           evict;
  logic                           walk_end;
  logic                           out_free;
  logic                           emit;

  assign key        = fwbc_pkg::TAG_BITS'(blk_q);
  assign walk_idx   = fwbc_pkg::wrap_idx(head_q, pos_q);
  assign append_idx = fwbc_pkg::wrap_idx(head_q, occ_q);
  assign walk_end   = (pos_q == occ_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (ways_q == '0) begin
      limit = fwbc_pkg::CNT_W'(1);
    end else if (int'(ways_q) > fwbc_pkg::NUM_ENTRIES) begin
      limit = fwbc_pkg::CNT_W'(fwbc_pkg::NUM_ENTRIES);
    end else begin
      limit = fwbc_pkg::CNT_W'(ways_q);
    end
  end

  assign evict = (occ_q >= limit) && (occ_q != '0);

  // At the end of an access walk the read port looks at the victim.
  always_comb begin
    query.idx  = (state_q == ST_SCAN && walk_end) ? head_q : walk_idx;
    query.head = head_q;
    query.occ  = occ_q;
    query.pos  = pos_q;
  end

  fwbc_dir_store u_store (
    .clk_i         (clk_i),
    .query_i       (query),
    .key_i         (key),
    .wr_i          (wr),
    .rd_tag_o      (rd_tag),
    .rd_dirty_o    (rd_dirty),
    .tag_eq_o      (tag_eq),
    .later_dirty_o (later_dirty)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    occ_d        = occ_q;
    pos_d        = pos_q;
    blk_d        = blk_q;
    wr_req_d     = wr_req_q;
    out_valid_d  = out_valid_q && out_stall_i;
    hit_d        = hit_q;
    slot_d       = slot_q;
    fill_valid_d = fill_valid_q;
    fill_block_d = fill_block_q;
    wb_valid_d   = wb_valid_q;
    wb_block_d   = wb_block_q;
    last_d       = last_q;
    emit         = 1'b0;
    wr           = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          blk_d    = block_number_i;
          wr_req_d = (req_type_i == fwbc_pkg::REQ_WRITE);
          pos_d    = '0;
          if (req_type_i == fwbc_pkg::REQ_READ || req_type_i == fwbc_pkg::REQ_WRITE) begin
            state_d = ST_SCAN;
          end else if (req_type_i == fwbc_pkg::REQ_SYNC) begin
            state_d = ST_SYNC;
          end
        end
      end
      ST_SCAN: begin
        if (!walk_end) begin
          if (tag_eq) begin
            if (out_free) begin
              emit         = 1'b1;
              hit_d        = 1'b1;
              slot_d       = fwbc_pkg::SLOT_W'(walk_idx);
              fill_valid_d = 1'b0;
              fill_block_d = '0;
              wb_valid_d   = 1'b0;
              wb_block_d   = '0;
              last_d       = 1'b1;
              wr.dirty_we  = wr_req_q;
              wr.idx       = walk_idx;
              wr.dirty     = 1'b1;
              state_d      = ST_IDLE;
            end
          end else begin
            pos_d = pos_q + fwbc_pkg::CNT_W'(1);
          end
        end else if (out_free) begin
          // Miss: retire the oldest entry if occupancy has reached the active-way limit, then append at the young end.
          emit         = 1'b1;
          hit_d        = 1'b0;
          slot_d       = fwbc_pkg::SLOT_W'(append_idx);
          fill_valid_d = 1'b1;
          fill_block_d = fwbc_pkg::BLK_W'(key);
          wb_valid_d   = evict && rd_dirty;
          wb_block_d   = (evict && rd_dirty) ? fwbc_pkg::BLK_W'(rd_tag) : '0;
          last_d       = 1'b1;
          wr.tag_we    = 1'b1;
          wr.dirty_we  = 1'b1;
          wr.idx       = append_idx;
          wr.tag       = key;
          wr.dirty     = wr_req_q;
          if (evict) begin
            head_d = fwbc_pkg::wrap_idx(head_q, fwbc_pkg::CNT_W'(1));
          end else begin
            occ_d = occ_q + fwbc_pkg::CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_SYNC: begin
        if (!walk_end) begin
          if (rd_dirty) begin
            if (out_free) begin
              emit         = 1'b1;
              hit_d        = 1'b0;
              slot_d       = fwbc_pkg::SLOT_W'(walk_idx);
              fill_valid_d = 1'b0;
              fill_block_d = '0;
              wb_valid_d   = 1'b1;
              wb_block_d   = fwbc_pkg::BLK_W'(rd_tag);
              last_d       = !later_dirty;
              wr.dirty_we  = 1'b1;
              wr.idx       = walk_idx;
              wr.dirty     = 1'b0;
              if (later_dirty) begin
                pos_d = pos_q + fwbc_pkg::CNT_W'(1);
              end else begin
                state_d = ST_IDLE;
              end
            end
          end else begin
            pos_d = pos_q + fwbc_pkg::CNT_W'(1);
          end
        end else if (out_free) begin
          // Nothing dirty: one empty closing transaction.
          emit         = 1'b1;
          hit_d        = 1'b0;
          slot_d       = '0;
          fill_valid_d = 1'b0;
          fill_block_d = '0;
          wb_valid_d   = 1'b0;
          wb_block_d   = '0;
          last_d       = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      occ_q        <= '0;
      pos_q        <= '0;
      ways_q       <= fwbc_pkg::WAYS_RESET;
      blk_q        <= '0;
      wr_req_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      slot_q       <= '0;
      fill_valid_q <= 1'b0;
      fill_block_q <= '0;
      wb_valid_q   <= 1'b0;
      wb_block_q   <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      occ_q        <= occ_d;
      pos_q        <= pos_d;
      blk_q        <= blk_d;
      wr_req_q     <= wr_req_d;
      out_valid_q  <= out_valid_d;
      hit_q        <= hit_d;
      slot_q       <= slot_d;
      fill_valid_q <= fill_valid_d;
      fill_block_q <= fill_block_d;
      wb_valid_q   <= wb_valid_d;
      wb_block_q   <= wb_block_d;
      last_q       <= last_d;
      if (cfg_valid_i) begin
        ways_q <= cfg_active_ways_i;
      end
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign slot_o       = slot_q;
  assign fill_valid_o = fill_valid_q;
  assign fill_block_o = fill_block_q;
  assign wb_valid_o   = wb_valid_q;
  assign wb_block_o   = wb_block_q;
  assign last_o       = last_q;

  `FWBC_ASSERT(a_occ_bound, 1'b1,
               occ_q <= fwbc_pkg::CNT_W'(fwbc_pkg::NUM_ENTRIES),
               "occupancy exceeds entry count")
  `FWBC_ASSERT(a_emit_no_overwrite, emit && out_valid_q, !out_stall_i,
               "result overwrites a stalled transaction")
  `FWBC_ASSERT(a_walk_bound, state_q != ST_IDLE, pos_q <= occ_q,
               "walk position beyond occupancy")
  `FWBC_ASSERT_NEXT(a_access_starts_walk,
                    state_q == ST_IDLE && in_valid_i &&
                    (req_type_i == fwbc_pkg::REQ_READ || req_type_i == fwbc_pkg::REQ_WRITE),
                    state_q == ST_SCAN && pos_q == '0,
                    "access did not start a walk")

endmodule
